// File: design/mcs_pkg.sv
`default_nettype none

package mcs_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned COUNT_W = 3;

  localparam logic [WORD_W-1:0]  CRC_POLY  = 32'hEDB8_8320;
  localparam logic [WORD_W-1:0]  ALL_ONES  = 32'hFFFF_FFFF;
  localparam logic [COUNT_W-1:0] MAX_BYTES = 3'd4;

  // Algorithm codes of the mode register.
  localparam logic MODE_XOR = 1'b0;
  localparam logic MODE_CRC = 1'b1;

  typedef struct packed {
    logic [WORD_W-1:0]  data_word;
    logic [COUNT_W-1:0] byte_count;
    logic               first;
  } mcs_item_t;

  // Effect of a single register bit after a number of reflected CRC shift
  // steps with zero data. Called with constant arguments to build XOR matrices.
  function automatic logic [WORD_W-1:0] crc_col(input int nbytes, input int bitpos);
    logic [WORD_W-1:0] v;
    v = '0;
    v[bitpos] = 1'b1;
    for (int k = 0; k < 8 * nbytes; k++) begin
      if (v[0]) begin
        v = (v >> 1) ^ CRC_POLY;
      end else begin
        v = v >> 1;
      end
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// File: design/multimode_checksum_stream_top.sv
// Streaming checksum engine, XOR-rotate or reflected CRC-32 (IEEE).
//
// Input channel (in_valid / in_stall): one transaction carries a little-endian
// data_word, a byte_count of valid low bytes (0 takes in nothing, 5 to 7 act
// as 4) and a first flag that reloads the running value for a new message.
// Output channel (out_valid / out_stall): one transaction per input carries
// the finalized checksum so far (inverted in CRC mode) and the byte total.
// Configuration channel (cfg_valid / cfg_ready): writes the mode bit, 0 for
// XOR-rotate and 1 for CRC. It is always ready and must only be written while
// no transaction is in flight.
//
// An accepted transaction is held in the input register, is computed in a
// single combinational pass and lands in the result register, which offers
// it. Throughput is one transaction per cycle unless the output stalls, as
// the running value is updated in the same combinational pass.
// A stalled result holds; the input register keeps taking one more
// transaction, after which in_stall rises until the output drains.
// Reset (rst, synchronous) empties both registers, sets CRC mode, loads the
// running value with all ones and clears the byte total.
`default_nettype none

module multimode_checksum_stream_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] data_word,
  input  wire logic [2:0]  byte_count,
  input  wire logic        first,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      checksum,
  output logic [31:0]      bytes_total,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        mode
);
  import mcs_pkg::*;

  logic        algo;
  logic [31:0] running_value;
  logic [31:0] byte_tally;
  logic        s1_valid;
  mcs_item_t   s1_item;
  logic        advance;
  logic        in_accept;
  logic [31:0] value_next;
  logic [31:0] tally_next;

  // The configuration register has no side effects, so it never waits.
  assign cfg_ready = 1'b1;

  // The input register moves forward whenever the result register is free
  // or being emptied in the same cycle.
  assign advance   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      algo <= MODE_CRC;
    end else if (cfg_valid && cfg_ready) begin
      algo <= mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item.data_word  <= data_word;
      s1_item.byte_count <= byte_count;
      s1_item.first      <= first;
    end
  end

  mcs_core u_core (
    .algo          (algo),
    .item          (s1_item),
    .running_value (running_value),
    .byte_tally    (byte_tally),
    .value_next    (value_next),
    .tally_next    (tally_next)
  );

  // The running state advances together with the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_value <= ALL_ONES;
      byte_tally    <= '0;
    end else if (advance) begin
      running_value <= value_next;
      byte_tally    <= tally_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      checksum    <= (algo == MODE_CRC) ? ~value_next : value_next;
      bytes_total <= tally_next;
    end
  end

`ifndef ASSERT_OFF
  a_no_stall_when_out_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while result register empty");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with empty input register");

  a_empty_restart_tally: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_item.first && (s1_item.byte_count == 3'd0)) |=> (bytes_total == 32'd0))
    else $error("restart with no bytes left a nonzero total");

  a_empty_restart_crc: assert property (@(posedge clk) disable iff (rst)
    (advance && (algo == MODE_CRC) && s1_item.first && (s1_item.byte_count == 3'd0))
      |=> (checksum == 32'd0))
    else $error("empty CRC restart did not give a zero checksum");
`endif

endmodule

`default_nettype wire

// File: design/mcs_core.sv
`default_nettype none

module mcs_core (
  input  wire logic               algo,
  input  wire mcs_pkg::mcs_item_t item,
  input  wire logic [31:0]        running_value,
  input  wire logic [31:0]        byte_tally,
  output logic [31:0]             value_next,
  output logic [31:0]             tally_next
);
  import mcs_pkg::*;

  logic [COUNT_W-1:0] count;
  logic [WORD_W-1:0]  base;
  logic [WORD_W-1:0]  tally_base;
  logic [WORD_W-1:0]  mixed;
  logic [WORD_W-1:0]  crc_by_len [4];
  logic [WORD_W-1:0]  xor_full;
  logic [WORD_W-1:0]  byte_mask;

  assign count = (item.byte_count > MAX_BYTES) ? MAX_BYTES : item.byte_count;

  // A first flag reloads the running value before the word is taken in.
  assign base       = item.first ? ((algo == MODE_CRC) ? ALL_ONES : '0) : running_value;
  assign tally_base = item.first ? '0 : byte_tally;

  // Only the valid low bytes of the word are mixed in.
  assign mixed = base ^ (item.data_word & byte_mask);

  // The CRC over n bytes is linear: each bit of (crc ^ data) below 8n
  // contributes a fixed column, bits above simply shift right by 8n.
  for (genvar n = 0; n < 4; n++) begin : g_len
    logic [WORD_W-1:0] acc;
    always_comb begin
      acc = '0;
      for (int j = 0; j < WORD_W; j++) begin
        if (mixed[j]) begin
          acc = acc ^ crc_col(n + 1, j);
        end
      end
      crc_by_len[n] = acc;
    end
  end

  assign xor_full = {mixed[WORD_W-2:0], mixed[WORD_W-1]};

  always_comb begin
    case (count)
      3'd1:    byte_mask = 32'h0000_00FF;
      3'd2:    byte_mask = 32'h0000_FFFF;
      3'd3:    byte_mask = 32'h00FF_FFFF;
      default: byte_mask = ALL_ONES;
    endcase
  end

  always_comb begin
    value_next = base;
    if (count != '0) begin
      if (algo == MODE_CRC) begin
        value_next = crc_by_len[count[1:0] - 2'd1];
      end else if (count == MAX_BYTES) begin
        value_next = xor_full;
      end else begin
        value_next = mixed;
      end
    end
  end

  assign tally_next = tally_base + {{(WORD_W-COUNT_W){1'b0}}, count};

endmodule

`default_nettype wire

// File: sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mcs_pkg::*;

  // One checksum result as the output channel presents it.
  typedef struct packed {
    logic [31:0] checksum;
    logic [31:0] bytes_total;
  } sum_t;

  // One row of the directed plan. A row is either a mode write or an input
  // transaction. Where chk is set, the expected result is typed in; all
  // other input rows are checked against the predictor.
  typedef struct packed {
    logic        cfg;
    logic        new_mode;
    logic [31:0] word;
    logic [2:0]  cnt;
    logic        fst;
    logic        chk;
    logic [31:0] ck;
    logic [31:0] tot;
  } step_t;

  localparam int NUM_DIRECTED = 25;
  localparam int NUM_PHASES   = 10;
  localparam int PHASE_ITEMS  = 145;
  localparam int HOLD_CYCLES  = 60;

  // Clock, reset and block inputs. Every input has a known value at time zero.
  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        in_valid   = 1'b0;
  logic [31:0] data_word  = '0;
  logic [2:0]  byte_count = '0;
  logic        first      = 1'b0;
  logic        out_stall  = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic        cfg_mode   = MODE_CRC;

  logic        in_stall;
  logic        out_valid;
  logic [31:0] checksum;
  logic [31:0] bytes_total;
  logic        cfg_ready;

  // Predictor state: its own copy of the mode register, the running value
  // and the byte tally, all at their reset values.
  logic        cur_mode = MODE_CRC;
  logic [31:0] run_val  = ALL_ONES;
  logic [31:0] tally    = '0;

  // Results still owed by the block, oldest first.
  sum_t        pending_sums[$];
  int          errors   = 0;
  bit          idle_on  = 1'b1;
  bit          hold_req = 1'b0;

  step_t       plan [NUM_DIRECTED] = '{
    // CRC mode after reset: a reload with no data finalizes to zero.
    '{1'b0, 1'b0, 32'hDEAD_BEEF, 3'd0, 1'b1, 1'b1, 32'h0000_0000, 32'd0},
    // A single zero byte has a well-known CRC-32.
    '{1'b0, 1'b0, 32'h0000_0000, 3'd1, 1'b1, 1'b1, 32'hD202_EF8D, 32'd1},
    // The check string "123456789" spread over three words; the unused
    // high bytes of the last word must not leak in.
    '{1'b0, 1'b0, 32'h3433_3231, 3'd4, 1'b1, 1'b0, 32'h0,         32'd0},
    '{1'b0, 1'b0, 32'h3837_3635, 3'd4, 1'b0, 1'b0, 32'h0,         32'd0},
    '{1'b0, 1'b0, 32'hFFFF_FF39, 3'd1, 1'b0, 1'b1, 32'hCBF4_3926, 32'd9},
    // A zero count takes nothing in.
    '{1'b0, 1'b0, 32'h1234_5678, 3'd0, 1'b0, 1'b1, 32'hCBF4_3926, 32'd9},
    // Counts above four act as four, then the partial counts.
    '{1'b0, 1'b0, 32'hFFFF_FFFF, 3'd5, 1'b0, 1'b0, 32'h0,         32'd0},
    '{1'b0, 1'b0, 32'h0F0F_0F0F, 3'd6, 1'b0, 1'b0, 32'h0,         32'd0},
    '{1'b0, 1'b0, 32'hF0F0_F0F0, 3'd7, 1'b0, 1'b0, 32'h0,         32'd0},
    '{1'b0, 1'b0, 32'hCAFE_F00D, 3'd2, 1'b0, 1'b0, 32'h0,         32'd0},
    '{1'b0, 1'b0, 32'h1357_9BDF, 3'd3, 1'b0, 1'b0, 32'h0,         32'd0},
    // Switch to XOR mode in the middle of a message.
    '{1'b1, MODE_XOR, 32'h0,     3'd0, 1'b0, 1'b0, 32'h0,         32'd0},
    '{1'b0, 1'b0, 32'hA5A5_A5A5, 3'd4, 1'b0, 1'b0, 32'h0,         32'd0},
    // XOR extremes, rotation on full words only.
    '{1'b0, 1'b0, 32'h0000_0000, 3'd4, 1'b1, 1'b1, 32'h0000_0000, 32'd4},
    '{1'b0, 1'b0, 32'hFFFF_FFFF, 3'd4, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'd4},
    '{1'b0, 1'b0, 32'h8000_0001, 3'd7, 1'b1, 1'b1, 32'h0000_0003, 32'd4},
    '{1'b0, 1'b0, 32'hFFFF_FFFF, 3'd1, 1'b1, 1'b1, 32'h0000_00FF, 32'd1},
    '{1'b0, 1'b0, 32'hFFFF_FFFF, 3'd2, 1'b0, 1'b1, 32'h0000_FF00, 32'd3},
    '{1'b0, 1'b0, 32'hFFFF_FFFF, 3'd3, 1'b0, 1'b1, 32'h00FF_00FF, 32'd6},
    '{1'b0, 1'b0, 32'h1234_5678, 3'd0, 1'b1, 1'b1, 32'h0000_0000, 32'd0},
    '{1'b0, 1'b0, 32'h89AB_CDEF, 3'd5, 1'b0, 1'b0, 32'h0,         32'd0},
    '{1'b0, 1'b0, 32'h7654_3210, 3'd6, 1'b0, 1'b0, 32'h0,         32'd0},
    // Back to CRC in the middle of a message.
    '{1'b1, MODE_CRC, 32'h0,     3'd0, 1'b0, 1'b0, 32'h0,         32'd0},
    '{1'b0, 1'b0, 32'h0000_0000, 3'd4, 1'b0, 1'b0, 32'h0,         32'd0},
    '{1'b0, 1'b0, 32'hFFFF_FFFF, 3'd4, 1'b1, 1'b0, 32'h0,         32'd0}
  };

  multimode_checksum_stream_top u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_word  (data_word),
    .byte_count (byte_count),
    .first      (first),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .checksum   (checksum),
    .bytes_total(bytes_total),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .mode       (cfg_mode)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advances the predictor by one input transaction and returns the result
  // that the block must produce for it. Counts of five to seven act as four,
  // a zero count only applies the reload.
  function automatic sum_t checksum_next(input logic [31:0] word, input logic [2:0] cnt,
                                         input logic fst);
    int unsigned n;
    sum_t        r;
    n = (cnt > 3'd4) ? 4 : int'(cnt);
    if (fst) begin
      run_val = (cur_mode == MODE_CRC) ? ALL_ONES : '0;
      tally   = '0;
    end
    if (n > 0) begin
      if (cur_mode == MODE_CRC) begin
        // Reflected CRC-32, lowest byte first, one bit per step.
        for (int i = 0; i < n; i++) begin
          run_val ^= {24'h0, word[8*i +: 8]};
          for (int b = 0; b < 8; b++) begin
            run_val = run_val[0] ? ((run_val >> 1) ^ CRC_POLY) : (run_val >> 1);
          end
        end
      end else if (n == 4) begin
        run_val ^= word;
        run_val = {run_val[30:0], run_val[31]};
      end else begin
        run_val ^= word & ((32'd1 << (8 * n)) - 32'd1);
      end
      tally += n;
    end
    r.checksum    = (cur_mode == MODE_CRC) ? ~run_val : run_val;
    r.bytes_total = tally;
    return r;
  endfunction

  // Offers one input transaction and waits until the block takes it. Must be
  // called right after a rising edge. The expectation is queued at the edge
  // of acceptance; a typed-in value replaces the predicted one.
  task automatic send_word(input logic [31:0] word, input logic [2:0] cnt, input logic fst,
                           input logic chk, input sum_t typed);
    sum_t predicted;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    data_word  <= word;
    byte_count <= cnt;
    first      <= fst;
    do @(posedge clk); while (in_stall);
    predicted = checksum_next(word, cnt, fst);
    pending_sums.push_back(chk ? typed : predicted);
  endtask

  // Lets every outstanding result come back, then a few quiet cycles so the
  // block is idle before the mode register changes.
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    cfg_valid <= 1'b1;
    cfg_mode  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_mode = m;
  endtask

  // A random message: a reload, mostly full words and often a partial word
  // at the end. A small share of words carries noise: any count from zero to
  // seven, or a stray reload in the middle.
  task automatic send_message(input int len);
    logic [2:0] cnt;
    logic       fst;
    for (int k = 0; k < len; k++) begin
      fst = (k == 0) || ($urandom_range(0, 29) == 0);
      if ($urandom_range(0, 11) == 0) begin
        cnt = 3'($urandom_range(0, 7));
      end else if (k == len - 1) begin
        cnt = 3'($urandom_range(1, 4));
      end else begin
        cnt = 3'd4;
      end
      send_word($urandom, cnt, fst, 1'b0, '0);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 32'h%08h, got 32'h%08h", name, want, got);
      errors++;
    end
  endtask

  // Result side. A result transaction completes on an edge where out_valid is
  // high and the testbench did not stall; it is compared with the oldest
  // expectation.
  always @(posedge clk) begin
    sum_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_sums.size() == 0) begin
        $error("result transaction with none expected: checksum 32'h%08h, bytes_total %0d",
               checksum, bytes_total);
        errors++;
      end else begin
        want = pending_sums.pop_front();
        check_field("checksum", want.checksum, checksum);
        check_field("bytes_total", want.bytes_total, bytes_total);
      end
    end
  end

  // Receiver back-pressure. Normally short random stall bursts; on request a
  // long hold-off, counted here, so the block fills and stalls its input.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Main sequence: reset, the directed plan, then random phases, each opened
  // with a mode write while the block is idle.
  initial begin
    int sent;
    int len;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].cfg) begin
        wait_drain();
        write_mode(plan[i].new_mode);
      end else begin
        send_word(plan[i].word, plan[i].cnt, plan[i].fst, plan[i].chk,
                  '{checksum: plan[i].ck, bytes_total: plan[i].tot});
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drain();
      // Both modes come early; later phases pick one at random.
      if (p == 0) begin
        write_mode(MODE_XOR);
      end else if (p == 1) begin
        write_mode(MODE_CRC);
      end else begin
        write_mode(($urandom_range(0, 1) == 0) ? MODE_XOR : MODE_CRC);
      end
      // The final phase runs at full rate on both sides.
      idle_on = (p != NUM_PHASES - 1);
      if (p == 2) begin
        hold_req = 1'b1;
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        len = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 12);
        send_message(len);
        sent += len;
        // Once, the sender stops until every result is back.
        if (p == 5 && sent >= PHASE_ITEMS / 2 && sent - len < PHASE_ITEMS / 2) begin
          wait_drain();
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// File: filelist.f
design/mcs_pkg.sv
design/mcs_core.sv
design/multimode_checksum_stream_top.sv
sim/tb.sv
